### sv/rc4we_pkg.sv
package rc4we_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int ADDR_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int WORD_BYTES = 4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;

    // One write port and two read ports of the S-box memory
    typedef struct packed {
        logic  we;
        addr_t waddr;
        byte_t wdata;
        addr_t raddr_a;
        addr_t raddr_b;
    } ram_req_t;

    // Sequencer handshake towards the output stage
    typedef struct packed {
        logic  idle;
        logic  res_valid;
        word_t res_word;
    } seq_status_t;

endpackage

### sv/rc4we_sbox_ram.sv
module rc4we_sbox_ram
(
    input  logic                     clk,
    input  rc4we_pkg::ram_req_t      req,
    output rc4we_pkg::byte_t         rd_a,
    output rc4we_pkg::byte_t         rd_b
);

    rc4we_pkg::byte_t mem [rc4we_pkg::SBOX_DEPTH];
    rc4we_pkg::byte_t rd_a_reg;
    rc4we_pkg::byte_t rd_b_reg;

    // read-first: a read of the entry being written returns the old value
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_a_reg <= mem[req.raddr_a];
        rd_b_reg <= mem[req.raddr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

### sv/rc4we_seq.sv
module rc4we_seq
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  rc4we_pkg::word_t            key_word,
    input  rc4we_pkg::word_t            data_word,
    input  logic                        res_take,
    input  rc4we_pkg::byte_t            rd_a,
    input  rc4we_pkg::byte_t            rd_b,
    output rc4we_pkg::ram_req_t         req,
    output rc4we_pkg::seq_status_t      status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KA,
        ST_KB,
        ST_KFLUSH,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_FINISH
    } state_t;

    state_t             state_reg,  state_next;
    rc4we_pkg::addr_t   cnt_reg,    cnt_next;
    rc4we_pkg::addr_t   j_reg,      j_next;
    rc4we_pkg::byte_t   si_reg,     si_next;
    rc4we_pkg::byte_t   sj_reg,     sj_next;
    rc4we_pkg::byte_t   psi_reg,    psi_next;
    rc4we_pkg::addr_t   pj_reg,     pj_next;
    logic               pend_reg,   pend_next;
    logic               fwdi_reg,   fwdi_next;
    logic               fwdj_reg,   fwdj_next;
    logic               ti_reg,     ti_next;
    logic               tj_reg,     tj_next;
    logic [1:0]         n_reg,      n_next;
    rc4we_pkg::word_t   key_reg,    key_next;
    rc4we_pkg::word_t   data_reg,   data_next;

    always_comb
    begin
        rc4we_pkg::byte_t s_i;
        rc4we_pkg::byte_t s_j;
        rc4we_pkg::byte_t kb;
        rc4we_pkg::byte_t t;
        rc4we_pkg::byte_t ks;
        rc4we_pkg::addr_t j_new;
        rc4we_pkg::addr_t i_inc;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        psi_next   = psi_reg;
        pj_next    = pj_reg;
        pend_next  = pend_reg;
        fwdi_next  = fwdi_reg;
        fwdj_next  = fwdj_reg;
        ti_next    = ti_reg;
        tj_next    = tj_reg;
        n_next     = n_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        req        = '0;
        s_i        = '0;
        s_j        = '0;
        kb         = '0;
        t          = '0;
        ks         = '0;
        j_new      = '0;
        i_inc      = cnt_reg + rc4we_pkg::ADDR_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key_word;
                    data_next  = data_word;
                    cnt_next   = '0;
                    state_next = ST_INIT;
                end
            end

            ST_INIT:
            begin
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = cnt_reg;
                cnt_next  = i_inc;
                if (cnt_reg == '1)
                begin
                    // prime the read of S[0] for the first schedule step
                    req.raddr_a = '0;
                    j_next      = '0;
                    pend_next   = 1'b0;
                    fwdi_next   = 1'b0;
                    state_next  = ST_KA;
                end
            end

            // S[i] arrives; finish the previous swap while reading S[j]
            ST_KA:
            begin
                s_i         = fwdi_reg ? psi_reg : rd_a;
                kb          = rc4we_pkg::BYTE_W'(key_reg >> {cnt_reg[1:0], 3'b000});
                j_new       = j_reg + s_i + kb;
                req.raddr_b = j_new;
                req.we      = pend_reg;
                req.waddr   = pj_reg;
                req.wdata   = psi_reg;
                fwdj_next   = pend_reg && (j_new == pj_reg);
                si_next     = s_i;
                j_next      = j_new;
                state_next  = ST_KB;
            end

            // S[j] arrives; write S[i] and fetch the next S[i]
            ST_KB:
            begin
                s_j       = fwdj_reg ? psi_reg : rd_b;
                req.we    = 1'b1;
                req.waddr = cnt_reg;
                req.wdata = s_j;
                psi_next  = si_reg;
                pj_next   = j_reg;
                pend_next = 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = ST_KFLUSH;
                end
                else
                begin
                    req.raddr_a = i_inc;
                    fwdi_next   = (j_reg == i_inc);
                    cnt_next    = i_inc;
                    state_next  = ST_KA;
                end
            end

            ST_KFLUSH:
            begin
                req.we     = 1'b1;
                req.waddr  = pj_reg;
                req.wdata  = psi_reg;
                cnt_next   = rc4we_pkg::ADDR_W'(1);
                j_next     = '0;
                n_next     = '0;
                state_next = ST_P0;
            end

            ST_P0:
            begin
                req.raddr_a = cnt_reg;
                state_next  = ST_P1;
            end

            ST_P1:
            begin
                s_i         = rd_a;
                j_new       = j_reg + s_i;
                req.raddr_b = j_new;
                si_next     = s_i;
                j_next      = j_new;
                state_next  = ST_P2;
            end

            // the keystream index read overlaps the write of S[i]; hits are forwarded
            ST_P2:
            begin
                s_j         = rd_b;
                req.we      = 1'b1;
                req.waddr   = cnt_reg;
                req.wdata   = s_j;
                sj_next     = s_j;
                t           = si_reg + s_j;
                req.raddr_a = t;
                ti_next     = (t == cnt_reg);
                tj_next     = (t == j_reg);
                state_next  = ST_P3;
            end

            ST_P3:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg;
                req.wdata = si_reg;
                ks        = ti_reg ? sj_reg : (tj_reg ? si_reg : rd_a);
                data_next = data_reg ^ (rc4we_pkg::WORD_W'(ks) << {n_reg, 3'b000});
                if (n_reg == 2'd3)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    n_next     = n_reg + 2'd1;
                    cnt_next   = i_inc;
                    state_next = ST_P0;
                end
            end

            ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            fwdi_reg  <= 1'b0;
            fwdj_reg  <= 1'b0;
            ti_reg    <= 1'b0;
            tj_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            fwdi_reg  <= fwdi_next;
            fwdj_reg  <= fwdj_next;
            ti_reg    <= ti_next;
            tj_reg    <= tj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        psi_reg  <= psi_next;
        pj_reg   <= pj_next;
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign status.idle      = (state_reg == ST_IDLE);
    assign status.res_valid = (state_reg == ST_FINISH);
    assign status.res_word  = data_reg;

endmodule

### sv/rc4_word_encrypt.sv
// Channel   Signals                          Payload
// s_axis    tvalid tready tdata[63:0]        key_word, data_word
// m_axis    tvalid tready tdata[31:0]        cipher_word
//
// Steps per word, in order: take the transfer, load the identity into the
// S-box, run the key schedule (each swap spread over ST_KA and ST_KB on the
// single write port of the S-box memory), retire the last swap, make the four
// keystream bytes and hand the word to the output register.
// Reset clears the control state only; every word rewrites the whole S-box.
// A word waiting in the output register does not block the next transfer in;
// the sequencer holds its finished word until the output register is free.
module rc4_word_encrypt
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,   // key_word [31:0], data_word [63:32]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata    // cipher_word [31:0]
);

    rc4we_pkg::ram_req_t    req;
    rc4we_pkg::seq_status_t status;
    rc4we_pkg::byte_t       rd_a;
    rc4we_pkg::byte_t       rd_b;
    logic                   res_take;
    logic                   out_valid_reg, out_valid_next;
    rc4we_pkg::word_t       out_data_reg;

    rc4we_sbox_ram u_ram
    (
        .clk   (clk),
        .req   (req),
        .rd_a  (rd_a),
        .rd_b  (rd_b)
    );

    rc4we_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && s_axis_tready),
        .key_word  (s_axis_tdata[31:0]),
        .data_word (s_axis_tdata[63:32]),
        .res_take  (res_take),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .req       (req),
        .status    (status)
    );

    assign s_axis_tready = status.idle;
    assign res_take      = status.res_valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= status.res_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
